>>> rtl/hce_pkg.sv
// Shared types, constants and helpers for the chunked transfer encoder.
// No dependencies; every other file except hce_ram uses it by scoped names.
package hce_pkg;

   localparam int CHUNK_MAX_DEFAULT = 32;
   localparam int LEN_W             = 6;
   localparam int CSR_W             = 6;
   localparam logic [CSR_W-1:0] CHUNK_SIZE_RESET = 6'd20;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   localparam logic [7:0] ASCII_CR   = 8'h0D;
   localparam logic [7:0] ASCII_LF   = 8'h0A;
   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_A    = 8'h41;

   typedef struct packed {
      logic             chunk;
      logic [LEN_W-1:0] len;
      logic             bank;
      logic             term;
   } cmd_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } release_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_HEX_HI,
      B_HEX_LO,
      B_CR1,
      B_LF1,
      B_DATA_RD,
      B_DATA_WR,
      B_CR2,
      B_LF2,
      B_T_ZERO,
      B_T_CR1,
      B_T_LF1,
      B_T_CR2,
      B_T_LF2
   } back_state_type;

   function automatic logic [7:0] hex_ascii(input logic [3:0] v);
      logic [7:0] r;
      if (v < 4'd10) begin
         r = ASCII_ZERO + {4'd0, v};
      end else begin
         r = ASCII_A + {4'd0, v - 4'd10};
      end
      return r;
   endfunction

endpackage

>>> rtl/hce_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module hce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/hce_front.sv
// Front end: accepts items, stores body bytes, decides chunk and terminator commands.
// Depends on hce_pkg; writes the chunk buffer RAM and feeds the command queue.
module hce_front #(
   parameter int CHUNK_MAX = hce_pkg::CHUNK_MAX_DEFAULT,
   parameter int IDX_W     = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [hce_pkg::CSR_W-1:0]  chunk_size,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic [7:0]                 req_data_byte,
   input  logic                       req_has_byte,
   input  logic                       req_end_of_body,
   output logic                       ram_wr_en,
   output logic [IDX_W:0]             ram_wr_addr,
   output logic [7:0]                 ram_wr_data,
   output logic                       q_push,
   output hce_pkg::cmd_type           q_data,
   input  logic                       q_full,
   input  hce_pkg::release_type       rel
);

   localparam logic [hce_pkg::LEN_W-1:0] MAX_LEN = hce_pkg::LEN_W'(CHUNK_MAX);

   logic [hce_pkg::LEN_W-1:0] fill_ff, fill_in;
   logic                      bank_ff, bank_in;
   logic [1:0]                busy_ff, busy_in;

   logic                      accept;
   logic [hce_pkg::LEN_W-1:0] eff_size;
   logic [hce_pkg::LEN_W-1:0] fill_new;
   logic                      do_chunk;

   always_comb begin
      if (chunk_size == '0) begin
         eff_size = hce_pkg::LEN_W'(1);
      end else if (chunk_size > MAX_LEN) begin
         eff_size = MAX_LEN;
      end else begin
         eff_size = chunk_size;
      end
   end

   assign req_full = q_full || busy_ff[bank_ff];
   assign accept   = req_push && !req_full;
   assign fill_new = req_has_byte ? fill_ff + hce_pkg::LEN_W'(1) : fill_ff;
   assign do_chunk = (req_has_byte && (fill_new >= eff_size))
                  || (req_end_of_body && (fill_new != '0));

   assign ram_wr_en   = accept && req_has_byte;
   assign ram_wr_addr = {bank_ff, fill_ff[IDX_W-1:0]};
   assign ram_wr_data = req_data_byte;

   assign q_push       = accept && (do_chunk || req_end_of_body);
   assign q_data.chunk = do_chunk;
   assign q_data.len   = fill_new;
   assign q_data.bank  = bank_ff;
   assign q_data.term  = req_end_of_body;

   always_comb begin
      fill_in = fill_ff;
      bank_in = bank_ff;
      busy_in = busy_ff;
      if (rel.valid) begin
         busy_in[rel.bank] = 1'b0;
      end
      if (accept) begin
         fill_in = (do_chunk || req_end_of_body) ? '0 : fill_new;
         if (do_chunk) begin
            bank_in          = !bank_ff;
            busy_in[bank_ff] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bank_ff <= 1'b0;
         busy_ff <= '0;
      end else begin
         fill_ff <= fill_in;
         bank_ff <= bank_in;
         busy_ff <= busy_in;
      end
   end

endmodule

>>> rtl/hce_queue.sv
// Two-entry command queue between the front end and the back end.
// Depends on hce_pkg for the command type and depth.
module hce_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  hce_pkg::cmd_type push_data,
   output logic             full,
   input  logic             pop,
   output hce_pkg::cmd_type pop_data,
   output logic             empty
);

   hce_pkg::cmd_type            entry_ff [hce_pkg::QDEPTH];
   logic [hce_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [hce_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [hce_pkg::QCNT_W-1:0]  count_ff, count_in;
   logic                        do_push, do_pop;

   assign full     = (count_ff == hce_pkg::QCNT_W'(hce_pkg::QDEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + hce_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + hce_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + hce_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - hce_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/hce_back.sv
// Back end: turns commands into the encoded byte stream through an output register.
// Depends on hce_pkg; reads the chunk buffer RAM and the command queue.
module hce_back #(
   parameter int CHUNK_MAX = hce_pkg::CHUNK_MAX_DEFAULT,
   parameter int IDX_W     = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   output logic                 q_pop,
   input  hce_pkg::cmd_type     q_data,
   output logic                 ram_rd_en,
   output logic [IDX_W:0]       ram_rd_addr,
   input  logic [7:0]           ram_rd_data,
   output hce_pkg::release_type rel,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [7:0]           rsp_out_byte,
   output logic                 rsp_last_of_run
);

   hce_pkg::back_state_type   state_ff, state_in;
   hce_pkg::cmd_type          cmd_ff, cmd_in;
   logic [hce_pkg::LEN_W-1:0] idx_ff, idx_in;
   logic                      out_valid_ff, out_valid_in;
   logic [7:0]                out_byte_ff, out_byte_in;
   logic                      out_last_ff, out_last_in;

   hce_pkg::back_state_type   nxt;
   logic                      emit, emit_last, can_load;
   logic [7:0]                emit_byte;

   assign can_load    = !out_valid_ff || rsp_pop;
   assign ram_rd_addr = {cmd_ff.bank, idx_ff[IDX_W-1:0]};

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      q_pop        = 1'b0;
      ram_rd_en    = 1'b0;
      rel          = '0;
      emit         = 1'b0;
      emit_last    = 1'b0;
      emit_byte    = hce_pkg::ASCII_CR;
      nxt          = state_ff;
      case (state_ff)
         hce_pkg::B_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cmd_in = q_data;
               idx_in = '0;
               if (!q_data.chunk) begin
                  state_in = hce_pkg::B_T_ZERO;
               end else if (q_data.len[hce_pkg::LEN_W-1:4] != '0) begin
                  state_in = hce_pkg::B_HEX_HI;
               end else begin
                  state_in = hce_pkg::B_HEX_LO;
               end
            end
         end
         hce_pkg::B_HEX_HI: begin
            emit      = 1'b1;
            emit_byte = hce_pkg::hex_ascii(4'(cmd_ff.len[hce_pkg::LEN_W-1:4]));
            nxt       = hce_pkg::B_HEX_LO;
         end
         hce_pkg::B_HEX_LO: begin
            emit      = 1'b1;
            emit_byte = hce_pkg::hex_ascii(cmd_ff.len[3:0]);
            nxt       = hce_pkg::B_CR1;
         end
         hce_pkg::B_CR1: begin
            emit = 1'b1;
            nxt  = hce_pkg::B_LF1;
         end
         hce_pkg::B_LF1: begin
            emit      = 1'b1;
            emit_byte = hce_pkg::ASCII_LF;
            nxt       = hce_pkg::B_DATA_RD;
         end
         hce_pkg::B_DATA_RD: begin
            ram_rd_en = 1'b1;
            state_in  = hce_pkg::B_DATA_WR;
         end
         hce_pkg::B_DATA_WR: begin
            emit      = 1'b1;
            emit_byte = ram_rd_data;
            nxt       = ((idx_ff + hce_pkg::LEN_W'(1)) == cmd_ff.len) ?
                        hce_pkg::B_CR2 : hce_pkg::B_DATA_RD;
         end
         hce_pkg::B_CR2: begin
            emit = 1'b1;
            nxt  = hce_pkg::B_LF2;
         end
         hce_pkg::B_LF2: begin
            emit      = 1'b1;
            emit_byte = hce_pkg::ASCII_LF;
            emit_last = !cmd_ff.term;
            nxt       = cmd_ff.term ? hce_pkg::B_T_ZERO : hce_pkg::B_IDLE;
         end
         hce_pkg::B_T_ZERO: begin
            emit      = 1'b1;
            emit_byte = hce_pkg::ASCII_ZERO;
            nxt       = hce_pkg::B_T_CR1;
         end
         hce_pkg::B_T_CR1: begin
            emit = 1'b1;
            nxt  = hce_pkg::B_T_LF1;
         end
         hce_pkg::B_T_LF1: begin
            emit      = 1'b1;
            emit_byte = hce_pkg::ASCII_LF;
            nxt       = hce_pkg::B_T_CR2;
         end
         hce_pkg::B_T_CR2: begin
            emit = 1'b1;
            nxt  = hce_pkg::B_T_LF2;
         end
         hce_pkg::B_T_LF2: begin
            emit      = 1'b1;
            emit_byte = hce_pkg::ASCII_LF;
            emit_last = 1'b1;
            nxt       = hce_pkg::B_IDLE;
         end
         default: begin
            state_in = hce_pkg::B_IDLE;
         end
      endcase
      if (emit && can_load) begin
         out_valid_in = 1'b1;
         out_byte_in  = emit_byte;
         out_last_in  = emit_last;
         state_in     = nxt;
         if (state_ff == hce_pkg::B_DATA_WR) begin
            idx_in = idx_ff + hce_pkg::LEN_W'(1);
         end
         if (state_ff == hce_pkg::B_LF2) begin
            rel.valid = 1'b1;
            rel.bank  = cmd_ff.bank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hce_pkg::B_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      idx_ff      <= idx_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

   a_last_is_lf: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_last_ff) |-> (out_byte_ff == hce_pkg::ASCII_LF))
      else $error("last item of a run is not LF");

   a_data_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hce_pkg::B_DATA_RD || state_ff == hce_pkg::B_DATA_WR)
      |-> (cmd_ff.chunk && (idx_ff < cmd_ff.len)))
      else $error("data index outside chunk");

   a_hex_hi_needed: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hce_pkg::B_HEX_HI) |-> (cmd_ff.len[hce_pkg::LEN_W-1:4] != '0))
      else $error("leading hex digit on short chunk");

   a_read_then_use: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hce_pkg::B_DATA_WR) |-> $past(ram_rd_en) || $stable(idx_ff))
      else $error("data used without a buffer read");

endmodule

>>> rtl/http_chunked_encoder_core.sv
// Top level of the HTTP chunked transfer encoder.
// Depends on hce_pkg, hce_ram, hce_front, hce_queue and hce_back.
//
//   channel  ports                                         handshake
//   req      req_data_byte, req_has_byte, req_end_of_body  req_push  & !req_full
//   rsp      rsp_out_byte, rsp_last_of_run                 rsp_pop   & !rsp_empty
//   csr      csr_data (chunk_size)                         csr_valid &  csr_ready
//
// Items enter at one per cycle while the two-entry command queue has room and
// the buffer bank being filled is not still being read out.
// Output: one framing byte per cycle while the output register can take it; each data
// byte takes a buffer RAM read, then an output register load.
// Reset is synchronous; no clearing pass, the buffer is only read where written.
// A full output register holds its item until popped; the front keeps filling meanwhile.
module http_chunked_encoder_core #(
   parameter int CHUNK_MAX = hce_pkg::CHUNK_MAX_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic [7:0]                req_data_byte,
   input  logic                      req_has_byte,
   input  logic                      req_end_of_body,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last_of_run,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [hce_pkg::CSR_W-1:0] csr_data
);

   localparam int IDX_W = (CHUNK_MAX > 1) ? $clog2(CHUNK_MAX) : 1;
   localparam int DEPTH = 2 ** (IDX_W + 1);

   logic [hce_pkg::CSR_W-1:0] chunk_size_ff, chunk_size_in;

   logic                 ram_wr_en, ram_rd_en;
   logic [IDX_W:0]       ram_wr_addr, ram_rd_addr;
   logic [7:0]           ram_wr_data, ram_rd_data;
   logic                 q_push, q_full, q_pop, q_empty;
   hce_pkg::cmd_type     q_in, q_out;
   hce_pkg::release_type rel;

   assign csr_ready     = 1'b1;
   assign chunk_size_in = (csr_valid && csr_ready) ? csr_data : chunk_size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_size_ff <= hce_pkg::CHUNK_SIZE_RESET;
      end else begin
         chunk_size_ff <= chunk_size_in;
      end
   end

   hce_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_buf (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   hce_front #(
      .CHUNK_MAX (CHUNK_MAX),
      .IDX_W     (IDX_W)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .chunk_size      (chunk_size_ff),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_end_of_body (req_end_of_body),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .q_push          (q_push),
      .q_data          (q_in),
      .q_full          (q_full),
      .rel             (rel)
   );

   hce_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   hce_back #(
      .CHUNK_MAX (CHUNK_MAX),
      .IDX_W     (IDX_W)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .q_data          (q_out),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rel             (rel),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
